// File: design/ili_pkg.sv
package ili_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = 9;
  localparam int INDEX_W  = 9;
  localparam int VALUE_W  = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0] CAPACITY_COUNT = COUNT_W'(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_INSERT,
    KIND_DELETE
  } eng_kind_t;

  typedef struct packed {
    logic                start;
    eng_kind_t           kind;
    logic [ADDR_W-1:0]   pos;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  value;
  } eng_cmd_t;

  typedef struct packed {
    logic                done;
    logic [VALUE_W-1:0]  rdata;
  } eng_rsp_t;

endpackage

// File: design/ili_engine.sv
module ili_engine
  import ili_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  eng_cmd_t cmd,
  output eng_rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ_WAIT,
    S_MOVE
  } state_t;

  state_t             state;
  eng_kind_t          kind;
  logic [ADDR_W-1:0]  pos;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] moves;
  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  last;
  logic               pend;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata;

  logic [ADDR_W-1:0]  raddr_sel;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [VALUE_W-1:0] wdata;
  logic               up;
  logic               moves_zero;

  assign up         = (kind == KIND_INSERT);
  assign moves_zero = (moves == '0);
  assign raddr_sel  = (state == S_IDLE) ? cmd.pos : raddr;
  assign we         = (state == S_MOVE) && (pend || (moves_zero && up));
  assign waddr      = pend ? (up ? last + ADDR_W'(1) : last - ADDR_W'(1)) : pos;
  assign wdata      = pend ? rdata : value;

  assign rsp.done  = (state == S_READ_WAIT) || ((state == S_MOVE) && moves_zero && !pend);
  assign rsp.rdata = rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr_sel];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (cmd.start) begin
            kind  <= cmd.kind;
            pos   <= cmd.pos;
            value <= cmd.value;
            case (cmd.kind)
              KIND_INSERT: begin
                moves <= cmd.count - {1'b0, cmd.pos};
                raddr <= cmd.count[ADDR_W-1:0] - ADDR_W'(1);
                state <= S_MOVE;
              end
              KIND_DELETE: begin
                moves <= cmd.count - {1'b0, cmd.pos} - COUNT_W'(1);
                raddr <= cmd.pos + ADDR_W'(1);
                state <= S_MOVE;
              end
              default: begin
                state <= S_READ_WAIT;
              end
            endcase
          end
        end
        S_READ_WAIT: begin
          state <= S_IDLE;
        end
        S_MOVE: begin
          pend <= !moves_zero;
          if (!moves_zero) begin
            last  <= raddr;
            raddr <= up ? raddr - ADDR_W'(1) : raddr + ADDR_W'(1);
            moves <= moves - COUNT_W'(1);
          end else if (!pend) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/indexed_list_insert_delete_core.sv
// Ordered list of up to 256 signed 32-bit values held in one memory with a
// read port and a write port. Each transfer on the input stream carries one
// operation (read, insert at head, insert at tail, insert at index, delete at
// index) and yields exactly one result transfer with the read value, a status
// and the list length after the operation. One operation is worked on at a
// time and tready stays low meanwhile. An insert or delete moves the affected
// entries one per cycle through the memory, from none up to 255 of them.
// Rejected operations (out of range, full, unknown code) never start the
// memory engine. No clearing pass is needed after reset.
module indexed_list_insert_delete_core
  import ili_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] operation, [11:3] index, [43:12] value, [47:44] zero
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] read_value, [33:32] status, [42:34] list_length, [47:43] zero
  output logic [47:0] m_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_DELIVER
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] count;
  logic               res_is_read;
  logic [VALUE_W-1:0] res_value;
  status_t            res_status;
  logic [COUNT_W-1:0] res_length;

  logic [VALUE_W-1:0]  out_value;
  status_t             out_status;
  logic [COUNT_W-1:0]  out_length;

  logic [OP_W-1:0]    in_op;
  logic [INDEX_W-1:0] in_index;
  logic [VALUE_W-1:0] in_value;
  logic               accept;

  logic               dec_engine;
  eng_kind_t          dec_kind;
  logic [INDEX_W-1:0] dec_pos;
  status_t            dec_status;
  logic [VALUE_W-1:0] dec_value;
  logic [COUNT_W-1:0] count_next;

  eng_cmd_t cmd;
  eng_rsp_t rsp;

  assign in_op    = s_tdata[2:0];
  assign in_index = s_tdata[11:3];
  assign in_value = s_tdata[43:12];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign m_tdata = {5'd0, out_length, out_status, out_value};

  always_comb begin
    dec_engine = 1'b0;
    dec_kind   = KIND_READ;
    dec_pos    = in_index;
    dec_status = ST_DONE;
    dec_value  = '0;
    count_next = count;
    case (in_op)
      OP_READ: begin
        if (in_index < count) begin
          dec_engine = 1'b1;
        end else begin
          dec_status = ST_RANGE;
          dec_value  = '1;
        end
      end
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
        dec_kind = KIND_INSERT;
        if (in_op == OP_INS_HEAD) begin
          dec_pos = '0;
        end else if (in_op == OP_INS_TAIL) begin
          dec_pos = count;
        end
        if (in_op == OP_INS_AT && in_index > count) begin
          dec_status = ST_RANGE;
        end else if (count >= CAPACITY_COUNT) begin
          dec_status = ST_FULL;
        end else begin
          dec_engine = 1'b1;
          count_next = count + COUNT_W'(1);
        end
      end
      OP_DELETE: begin
        dec_kind = KIND_DELETE;
        if (in_index >= count) begin
          dec_status = ST_RANGE;
        end else begin
          dec_engine = 1'b1;
          count_next = count - COUNT_W'(1);
        end
      end
      default: begin
        dec_status = ST_RANGE;
      end
    endcase
  end

  assign cmd.start = accept && dec_engine;
  assign cmd.kind  = dec_kind;
  assign cmd.pos   = dec_pos[ADDR_W-1:0];
  assign cmd.count = count;
  assign cmd.value = in_value;

  ili_engine u_engine (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == S_DELIVER) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            count       <= count_next;
            res_is_read <= (dec_kind == KIND_READ);
            res_value   <= dec_value;
            res_status  <= dec_status;
            res_length  <= count_next;
            state       <= dec_engine ? S_WORK : S_DELIVER;
          end
        end
        S_WORK: begin
          if (rsp.done) begin
            if (res_is_read) begin
              res_value <= rsp.rdata;
            end
            state <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (!m_tvalid || m_tready) begin
            out_value  <= res_value;
            out_status <= res_status;
            out_length <= res_length;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
